/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl files
// no dependencies; bodies compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/utf8d_pkg.sv */
// constants, codes and types of the utf-32 to utf-8 decoder
// no dependencies
`timescale 1ns / 1ps
package utf8d_pkg;
   localparam int MAX_UNITS   = 64;
   localparam int POS_W       = $clog2(MAX_UNITS + 1);
   localparam int CPE_W       = 7;
   localparam int CSR_IDX_W   = 1;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_BIG_ENDIAN = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEM_LEN   = 1'd1;

   localparam logic [CPE_W-1:0] CHARS_RESET = 7'd16;

   localparam logic [31:0] CP_MAX     = 32'h0010_FFFF;
   localparam logic [31:0] SURR_FIRST = 32'h0000_D800;
   localparam logic [31:0] SURR_LAST  = 32'h0000_DFFF;
   localparam logic [31:0] LIMIT_1    = 32'h0000_0080;
   localparam logic [31:0] LIMIT_2    = 32'h0000_0800;
   localparam logic [31:0] LIMIT_3    = 32'h0001_0000;

   localparam logic [7:0] LEAD_2 = 8'hC0;
   localparam logic [7:0] LEAD_3 = 8'hE0;
   localparam logic [7:0] LEAD_4 = 8'hF0;
   localparam logic [7:0] CONT   = 8'h80;

   // one classified code unit: encoded bytes plus trailing flag results
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      nbytes;
      logic            bad;
      logic            str_end;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;
endpackage

/* rtl/core/utf8d_front.sv */
// front end: config registers, code unit assembly, classification, element state
// depends on utf8d_pkg
`timescale 1ns / 1ps
module utf8d_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [utf8d_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [utf8d_pkg::CPE_W-1:0]         csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [31:0]                         req_raw_word,
   input  logic                                req_last_in_array,
   input  utf8d_pkg::queue_status_type         qstat,
   output logic                                push,
   output utf8d_pkg::entry_type                push_entry
);
   import utf8d_pkg::*;

   logic             big_endian_ff;
   logic [CPE_W-1:0] chars_ff;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             skip_ff, skip_in;

   logic [31:0]      cp;
   logic [POS_W-1:0] eff_len;
   logic [POS_W-1:0] next_pos;
   logic             elem_end;
   logic             is_zero;
   logic             is_bad;
   logic             accept;
   entry_type        entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff <= 1'b0;
         chars_ff      <= CHARS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BIG_ENDIAN: big_endian_ff <= csr_wdata[0];
            CSR_ELEM_LEN:   chars_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cp = big_endian_ff ?
               {req_raw_word[7:0], req_raw_word[15:8], req_raw_word[23:16],
                req_raw_word[31:24]} : req_raw_word;

   always_comb begin
      if (chars_ff == '0) begin
         eff_len = POS_W'(1);
      end else if (32'(chars_ff) > MAX_UNITS) begin
         eff_len = POS_W'(MAX_UNITS);
      end else begin
         eff_len = POS_W'(chars_ff);
      end
   end

   assign next_pos = pos_ff + POS_W'(1);
   assign elem_end = (next_pos >= eff_len) || req_last_in_array;
   assign is_zero  = (cp == '0);
   assign is_bad   = (cp > CP_MAX) || ((cp >= SURR_FIRST) && (cp <= SURR_LAST));

   always_comb begin
      entry         = '0;
      entry.str_end = elem_end;
      if (!skip_ff && !is_zero) begin
         priority if (is_bad) begin
            entry.bad = 1'b1;
         end else if (cp < LIMIT_1) begin
            entry.nbytes   = 3'd1;
            entry.bytes[0] = cp[7:0];
         end else if (cp < LIMIT_2) begin
            entry.nbytes   = 3'd2;
            entry.bytes[0] = LEAD_2 | {3'b000, cp[10:6]};
            entry.bytes[1] = CONT | {2'b00, cp[5:0]};
         end else if (cp < LIMIT_3) begin
            entry.nbytes   = 3'd3;
            entry.bytes[0] = LEAD_3 | {4'b0000, cp[15:12]};
            entry.bytes[1] = CONT | {2'b00, cp[11:6]};
            entry.bytes[2] = CONT | {2'b00, cp[5:0]};
         end else begin
            entry.nbytes   = 3'd4;
            entry.bytes[0] = LEAD_4 | {5'b00000, cp[20:18]};
            entry.bytes[1] = CONT | {2'b00, cp[17:12]};
            entry.bytes[2] = CONT | {2'b00, cp[11:6]};
            entry.bytes[3] = CONT | {2'b00, cp[5:0]};
         end
      end
   end

   assign req_stall  = qstat.full;
   assign accept     = req_valid && !qstat.full;
   assign push       = accept && ((entry.nbytes != 3'd0) || entry.bad || entry.str_end);
   assign push_entry = entry;

   always_comb begin
      pos_in  = pos_ff;
      skip_in = skip_ff;
      if (accept) begin
         if (elem_end) begin
            pos_in  = '0;
            skip_in = 1'b0;
         end else begin
            pos_in  = next_pos;
            skip_in = skip_ff || is_zero || is_bad;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         skip_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         skip_ff <= skip_in;
      end
   end
endmodule

/* rtl/core/utf8d_queue.sv */
// short queue of classified code units between front and back end
// depends on utf8d_pkg
`timescale 1ns / 1ps
module utf8d_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  utf8d_pkg::entry_type        push_entry,
   input  logic                        pop,
   output utf8d_pkg::entry_type        head,
   output utf8d_pkg::queue_status_type qstat
);
   import utf8d_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head        = slot_ff[rd_ptr_ff];
   assign qstat.empty = (count_ff == '0);
   assign qstat.full  = (32'(count_ff) == QUEUE_DEPTH);
endmodule

/* rtl/core/utf8d_back.sv */
// back end: walks one queued entry result by result into the output register
// depends on utf8d_pkg
`timescale 1ns / 1ps
module utf8d_back (
   input  logic                        clock,
   input  logic                        reset,
   input  utf8d_pkg::entry_type        head,
   input  utf8d_pkg::queue_status_type qstat,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_byte_valid,
   output logic                        rsp_string_end,
   output logic                        rsp_bad_code_point,
   output logic                        rsp_last
);
   import utf8d_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       byte_valid_ff, byte_valid_in;
   logic       end_ff, end_in;
   logic       bad_ff, bad_in;
   logic       last_ff;
   logic [2:0] step_ff, step_in;
   logic [2:0] total;
   logic       load;
   logic       is_last;

   assign total   = head.nbytes + {2'b00, head.bad} + {2'b00, head.str_end};
   assign load    = !qstat.empty && (!rsp_valid_ff || !rsp_stall);
   assign is_last = (step_ff == total - 3'd1);
   assign pop     = load && is_last;

   always_comb begin
      byte_in       = '0;
      byte_valid_in = 1'b0;
      end_in        = 1'b0;
      bad_in        = 1'b0;
      priority if (step_ff < head.nbytes) begin
         byte_in       = head.bytes[step_ff[1:0]];
         byte_valid_in = 1'b1;
      end else if ((step_ff == head.nbytes) && head.bad) begin
         bad_in = 1'b1;
      end else begin
         end_in = 1'b1;
      end
   end

   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         step_in      = is_last ? 3'd0 : step_ff + 3'd1;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff       <= byte_in;
         byte_valid_ff <= byte_valid_in;
         end_ff        <= end_in;
         bad_ff        <= bad_in;
         last_ff       <= is_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_byte       = byte_ff;
   assign rsp_byte_valid     = byte_valid_ff;
   assign rsp_string_end     = end_ff;
   assign rsp_bad_code_point = bad_ff;
   assign rsp_last           = last_ff;
endmodule

/* rtl/core/fixed_utf32_to_utf8_decoder.sv */
// top level of the utf-32 to utf-8 decoder
// depends on utf8d_pkg, utf8d_front, utf8d_queue, utf8d_back, assert_macros.svh
`timescale 1ns / 1ps
// usage:
//   req channel carries one raw 32-bit code unit per transaction, with a flag for
//   the last unit of the array; rsp channel carries one result per transaction:
//   a utf-8 byte, an error flag or an end-of-string flag, with rsp_last on the
//   final result of each code unit. units that produce nothing give no result.
//   csr port writes big_endian (index 0) and the element length in code units
//   (index 1); the user must do so while the block is idle; it is not enforced.
//   path: the first result of a unit passes the queue slot and then the output
//   register before it is on rsp, when the output side is free.
//   throughput: one result per cycle while rsp is not stalled, up to five results
//   per code unit; the byte-wide output register sets this, and the two-entry
//   queue lets the req side run ahead while earlier units drain.
//   reset: synchronous, empties the queue, clears rsp_valid, the result step,
//   element position and skip flag, and loads the register reset values.
//   a stalled rsp holds its payload; once the queue fills, req_stall rises.
module fixed_utf32_to_utf8_decoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [utf8d_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [utf8d_pkg::CPE_W-1:0]     csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [31:0]                     req_raw_word,
   input  logic                            req_last_in_array,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_byte_valid,
   output logic                            rsp_string_end,
   output logic                            rsp_bad_code_point,
   output logic                            rsp_last
);
   import utf8d_pkg::*;
`include "assert_macros.svh"

   queue_status_type qstat;
   entry_type        push_entry;
   entry_type        head;
   logic             push;
   logic             pop;

   utf8d_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_raw_word      (req_raw_word),
      .req_last_in_array (req_last_in_array),
      .qstat             (qstat),
      .push              (push),
      .push_entry        (push_entry)
   );

   utf8d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   utf8d_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .qstat              (qstat),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_string_end     (rsp_string_end),
      .rsp_bad_code_point (rsp_bad_code_point),
      .rsp_last           (rsp_last)
   );

   `ASSERT_ALWAYS(a_queue_sane, clock, reset, !(qstat.empty && qstat.full))
   `ASSERT_IMPLY(a_one_kind, clock, reset, rsp_valid, $onehot({rsp_byte_valid, rsp_string_end, rsp_bad_code_point}))
   `ASSERT_IMPLY(a_end_is_last, clock, reset, rsp_valid && rsp_string_end, rsp_last)
   `ASSERT_IMPLY(a_no_pop_empty, clock, reset, qstat.empty, !pop)
endmodule
